// ===== hw/rtl/wrpm_pkg.sv =====
// wrpm_pkg: widths, limits, state codes and shared types for the windowed RMS power meter.
// No dependencies; every other file imports it.
package wrpm_pkg;

   localparam int MaxWindow = 65536;

   localparam int SampleW  = 10;
   localparam int BiasW    = 10;
   localparam int CoefW    = 16;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam int RmsW     = 18;
   localparam int PowerW   = 24;
   localparam int WinCntW  = 17;

   localparam int CountW = $clog2(MaxWindow + 1);
   localparam int SqrW   = 2 * (SampleW + 1);
   localparam int SumW   = 35;
   localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

   // divide (sum << 16) / count, then take the root of the quotient
   localparam int DivW  = SumW + 16;
   localparam int SqW   = DivW + (DivW % 2);
   localparam int RootW = SqW / 2;
   localparam int AluW  = (CountW + 2 > RootW + 4) ? CountW + 2 : RootW + 4;
   localparam int StepW = $clog2(DivW);

   localparam int DiffW = RmsW + 1;
   localparam int ProdW = DiffW + CoefW + 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ADC_BIAS   = 2'd0,
      CSR_RMS_OFFSET = 2'd1,
      CSR_POWER_GAIN = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_SQRT = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic [SumW-1:0]   sum;
      logic [CountW-1:0] count;
      logic              overflow;
   } window_type;

   typedef struct packed {
      logic [RmsW-1:0]          rms;
      logic signed [PowerW-1:0] power;
      logic [WinCntW-1:0]       count;
      logic                     overflow;
   } result_type;

endpackage

// ===== hw/rtl/wrpm_alu.sv =====
// wrpm_alu: shared subtract-and-compare unit for the divide and square-root steps.
// Depends on wrpm_pkg.
module wrpm_alu (
   input  logic [wrpm_pkg::AluW-1:0] a,
   input  logic [wrpm_pkg::AluW-1:0] b,
   output logic [wrpm_pkg::AluW-1:0] diff,
   output logic                      ge
);
   import wrpm_pkg::*;

   logic [AluW:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign diff = wide[AluW-1:0];
   assign ge   = ~wide[AluW];
endmodule

// ===== hw/rtl/wrpm_accum.sv =====
// wrpm_accum: bias removal, square and saturating running sum with sample count.
// Depends on wrpm_pkg.
module wrpm_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         last,
   input  logic [wrpm_pkg::SampleW-1:0] sample,
   input  logic [wrpm_pkg::BiasW-1:0]   adc_bias,
   output wrpm_pkg::window_type         win_next
);
   import wrpm_pkg::*;

   logic [SumW-1:0]         sum_ff, sum_in;
   logic [CountW-1:0]       count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic signed [SampleW:0] delta;
   logic signed [SqrW-1:0]  square;
   logic [SumW:0]           sum_add;
   logic                    full;

   assign delta   = $signed({1'b0, sample}) - $signed({1'b0, adc_bias});
   assign square  = SqrW'(delta) * SqrW'(delta);
   assign sum_add = {1'b0, sum_ff} + (SumW + 1)'($unsigned(square));
   assign full    = count_ff >= CountW'(MaxWindow);

   always_comb begin
      win_next.sum      = sum_ff;
      win_next.count    = count_ff;
      win_next.overflow = ovf_ff;
      if (full) begin
         win_next.overflow = 1'b1;
      end else begin
         win_next.sum   = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
         win_next.count = count_ff + 1'b1;
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         // the flagged sample closes the window: clear after the snapshot
         if (last) begin
            sum_in   = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sum_in   = win_next.sum;
            count_in = win_next.count;
            ovf_in   = win_next.overflow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end
endmodule

// ===== hw/rtl/wrpm_engine.sv =====
// wrpm_engine: sequencer for restoring divide, digit-by-digit root and power scaling.
// Depends on wrpm_pkg and wrpm_alu.
module wrpm_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  wrpm_pkg::window_type       win,
   input  logic [wrpm_pkg::CoefW-1:0] rms_offset,
   input  logic [wrpm_pkg::CoefW-1:0] power_gain,
   input  logic                       res_take,
   output logic                       busy,
   output logic                       res_valid,
   output wrpm_pkg::result_type       res
);
   import wrpm_pkg::*;

   localparam int PShW  = ProdW - 8;
   localparam int CntPW = (CountW > WinCntW) ? CountW : WinCntW;
   localparam logic signed [PShW-1:0] PowMax = PShW'(8388607);
   localparam logic signed [PShW-1:0] PowMin = -PShW'(8388608);

   state_type               state_ff, state_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic [AluW-1:0]         rem_ff, rem_in;
   logic [DivW-1:0]         quo_ff, quo_in;
   logic [SqW-1:0]          rad_ff, rad_in;
   logic [RootW-1:0]        root_ff, root_in;
   logic [CountW-1:0]       divisor_ff, divisor_in;
   logic                    zero_ff, zero_in;
   logic [WinCntW-1:0]      cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;

   logic [AluW-1:0]         alu_a, alu_b, alu_diff;
   logic                    alu_ge;
   logic [AluW-1:0]         div_shift, sq_shift, sq_trial;
   logic [DivW-1:0]         quo_next;
   logic [CntPW-1:0]        cnt_pad;
   logic signed [DiffW-1:0] rms_diff;
   logic signed [PShW-1:0]  pow_sh;

   wrpm_alu u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .diff (alu_diff),
      .ge   (alu_ge)
   );

   assign div_shift = {rem_ff[AluW-2:0], quo_ff[DivW-1]};
   assign sq_shift  = {rem_ff[AluW-3:0], rad_ff[SqW-1 -: 2]};
   assign sq_trial  = AluW'({root_ff, 2'b01});
   assign quo_next  = {quo_ff[DivW-2:0], alu_ge};
   assign cnt_pad   = CntPW'(win.count);
   assign rms_diff  = $signed({1'b0, root_ff[RmsW-1:0]}) - $signed(DiffW'(rms_offset));
   // arithmetic shift of the product floors toward minus infinity
   assign pow_sh    = prod_ff[ProdW-1:8];

   always_comb begin
      alu_a = sq_shift;
      alu_b = sq_trial;
      if (state_ff == ST_DIV) begin
         alu_a = div_shift;
         alu_b = AluW'(divisor_ff);
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      rad_in     = rad_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      zero_in    = zero_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      prod_in    = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quo_in     = DivW'({win.sum, 16'b0});
               divisor_in = win.count;
               zero_in    = (win.count == '0);
               cnt_in     = cnt_pad[WinCntW-1:0];
               ovf_in     = win.overflow;
               rem_in     = '0;
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = alu_ge ? alu_diff : div_shift;
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(DivW - 1)) begin
               // empty window reads as a zero root
               rad_in   = zero_ff ? '0 : SqW'(quo_next);
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rem_in  = alu_ge ? alu_diff : sq_shift;
            root_in = {root_ff[RootW-2:0], alu_ge};
            rad_in  = {rad_ff[SqW-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(RootW - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = ProdW'(rms_diff) * ProdW'($signed({1'b0, power_gain}));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      rad_ff     <= rad_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
      zero_ff    <= zero_in;
      cnt_ff     <= cnt_in;
      ovf_ff     <= ovf_in;
      prod_ff    <= prod_in;
   end

   always_comb begin
      res.rms      = root_ff[RmsW-1:0];
      res.count    = cnt_ff;
      res.overflow = ovf_ff;
      if (pow_sh > PowMax) begin
         res.power = PowMax[PowerW-1:0];
      end else if (pow_sh < PowMin) begin
         res.power = PowMin[PowerW-1:0];
      end else begin
         res.power = pow_sh[PowerW-1:0];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
endmodule

// ===== hw/rtl/windowed_rms_power_meter.sv =====
// windowed_rms_power_meter: top level with register file, accumulator, engine and result register.
// Depends on wrpm_pkg, wrpm_accum, wrpm_engine.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  sample, last_sample
//   rsp_     out        rsp_valid/rsp_stall  rms_q8, power_q8, window_count, window_overflow
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A sample without the last flag only adds to the running sum; the next may follow at once.
// A flagged sample occupies the engine for 51 restoring divide steps and 26 root steps
// through the one shared subtractor, then a multiply state and a hand-off state.
// req_stall is high while the engine runs; a result waiting on rsp_stall holds the engine
// only if the next window finishes before it is taken. Reset restores register defaults
// and clears the window sum, count and overflow flag.
module windowed_rms_power_meter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wrpm_pkg::SampleW-1:0]        req_sample,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wrpm_pkg::RmsW-1:0]           rsp_rms_q8,
   output logic signed [wrpm_pkg::PowerW-1:0]  rsp_power_q8,
   output logic [wrpm_pkg::WinCntW-1:0]        rsp_window_count,
   output logic                                rsp_window_overflow,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wrpm_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [wrpm_pkg::CsrDataW-1:0]       csr_wdata
);
   import wrpm_pkg::*;

   logic [BiasW-1:0] bias_ff, bias_in;
   logic [CoefW-1:0] offset_ff, offset_in;
   logic [CoefW-1:0] gain_ff, gain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       out_ff, out_in;

   window_type       win_next;
   result_type       res;
   logic             busy, res_valid, res_take, accept, out_free;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid & ~busy;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign res_take  = res_valid & out_free;

   wrpm_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .last     (req_last_sample),
      .sample   (req_sample),
      .adc_bias (bias_ff),
      .win_next (win_next)
   );

   wrpm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (accept & req_last_sample),
      .win        (win_next),
      .rms_offset (offset_ff),
      .power_gain (gain_ff),
      .res_take   (res_take),
      .busy       (busy),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      bias_in   = bias_ff;
      offset_in = offset_ff;
      gain_in   = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ADC_BIAS:   bias_in   = csr_wdata[BiasW-1:0];
            CSR_RMS_OFFSET: offset_in = csr_wdata;
            CSR_POWER_GAIN: gain_in   = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         // drop the transaction once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff      <= BiasW'(511);
         offset_ff    <= CoefW'(242);
         gain_ff      <= CoefW'(2476);
         rsp_valid_ff <= 1'b0;
      end else begin
         bias_ff      <= bias_in;
         offset_ff    <= offset_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rms_q8          = out_ff.rms;
   assign rsp_power_q8        = out_ff.power;
   assign rsp_window_count    = out_ff.count;
   assign rsp_window_overflow = out_ff.overflow;
endmodule

// ===== sim/tb_windowed_rms_power_meter.sv =====
`timescale 1ns / 1ps
// tb_windowed_rms_power_meter: self-checking testbench for the windowed RMS power meter.
// Depends on wrpm_pkg and windowed_rms_power_meter; predicts each window result and checks it.
module tb_windowed_rms_power_meter;
   import wrpm_pkg::*;

   typedef longint unsigned u64_t;

   localparam int ClockHalf    = 6;
   localparam int ResetCycles  = 6;
   localparam int EngineSettle = 120;
   localparam int CycleLimit   = 1000000;
   localparam int RandomItems  = 400;
   localparam int SampleTop    = (1 << SampleW) - 1;
   localparam longint PowerTop    = 64'sd8388607;
   localparam longint PowerBottom = -64'sd8388608;
   localparam logic [CsrIdxW-1:0] CsrUnmapped = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [SampleW-1:0]         req_sample;
   logic                       req_last_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [RmsW-1:0]            rsp_rms_q8;
   logic signed [PowerW-1:0]   rsp_power_q8;
   logic [WinCntW-1:0]         rsp_window_count;
   logic                       rsp_window_overflow;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CsrIdxW-1:0]         csr_index;
   logic [CsrDataW-1:0]        csr_wdata;

   // shadow registers and window accumulator of the predictor
   logic [BiasW-1:0]  bias_cfg;
   logic [CoefW-1:0]  offset_cfg;
   logic [CoefW-1:0]  gain_cfg;
   logic [SumW-1:0]   acc_sum;
   logic [CountW-1:0] acc_count;
   logic              acc_overflow;

   result_type window_results_q[$];
   result_type got_result;
   result_type want_result;

   int  error_count;
   int  windows_checked;
   int  samples_sent;
   int  cycle_count;
   bit  idle_on;
   bit  stall_on;

   windowed_rms_power_meter u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rms_q8          (rsp_rms_q8),
      .rsp_power_q8        (rsp_power_q8),
      .rsp_window_count    (rsp_window_count),
      .rsp_window_overflow (rsp_window_overflow),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_window_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 95) return $urandom_range(9, 40);
      return $urandom_range(41, 200);
   endfunction

   // mostly a wave around the bias, some full-scale noise and rail codes
   function automatic logic [SampleW-1:0] pick_sample();
      int r;
      int amp;
      int swing;
      int v;
      r = $urandom_range(0, 9);
      if (r < 2) return SampleW'($urandom_range(0, SampleTop));
      if (r == 2) return ($urandom_range(0, 1) != 0) ? SampleW'(SampleTop) : '0;
      amp   = $urandom_range(0, 400);
      swing = $urandom_range(0, 2 * amp);
      v     = int'(bias_cfg) + swing - amp;
      if (v < 0) v = 0;
      if (v > SampleTop) v = SampleTop;
      return SampleW'(v);
   endfunction

   function automatic logic [CsrDataW-1:0] pick_reg_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 6) return CsrDataW'($urandom_range(0, 4095));
      return CsrDataW'($urandom_range(0, 65535));
   endfunction

   function automatic u64_t int_root(input u64_t v);
      u64_t root;
      u64_t trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (u64_t'(1) << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // accumulate one sample; on the flagged one, queue the window result and clear
   task automatic meter_predict(input logic [SampleW-1:0] s, input logic last);
      longint     d;
      u64_t       total;
      u64_t       root;
      longint     prod;
      longint     pw;
      result_type res;
      if (int'(acc_count) >= MaxWindow) begin
         acc_overflow = 1'b1;
      end else begin
         d     = longint'(s) - longint'(bias_cfg);
         total = u64_t'(acc_sum) + u64_t'(d * d);
         acc_sum   = (total > u64_t'(SumMax)) ? SumMax : total[SumW-1:0];
         acc_count = acc_count + 1'b1;
      end
      if (last) begin
         root = 0;
         if (acc_count != 0) root = int_root((u64_t'(acc_sum) << 16) / u64_t'(acc_count));
         prod = (longint'(root) - longint'(offset_cfg)) * longint'(gain_cfg);
         pw   = prod >>> 8;
         if (pw > PowerTop) pw = PowerTop;
         if (pw < PowerBottom) pw = PowerBottom;
         res.rms      = root[RmsW-1:0];
         res.power    = pw[PowerW-1:0];
         res.count    = acc_count[WinCntW-1:0];
         res.overflow = acc_overflow;
         window_results_q.push_back(res);
         acc_sum      = '0;
         acc_count    = '0;
         acc_overflow = 1'b0;
      end
   endtask

   task automatic send_sample(input logic [SampleW-1:0] s, input logic last);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      meter_predict(s, last);
      samples_sent++;
   endtask

   task automatic send_window(input int len);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
   endtask

   // drop valid, wait out every pending window, then let the engine go quiet
   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (window_results_q.size() != 0) @(posedge clock);
      repeat (EngineSettle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ADC_BIAS:   bias_cfg   = data[BiasW-1:0];
         CSR_RMS_OFFSET: offset_cfg = data;
         CSR_POWER_GAIN: gain_cfg   = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_sample(10'd511, 1'b1);
      send_sample(10'd1023, 1'b1);
      send_sample(10'd0, 1'b1);
      send_sample(10'd0, 1'b0);
      send_sample(10'd1023, 1'b0);
      send_sample(10'd511, 1'b0);
      send_sample(10'd700, 1'b1);
      wait_results();
   endtask

   task automatic test_register_extremes();
      // all-ones write to the bias lands as the 10-bit maximum
      write_reg(CSR_ADC_BIAS, 16'hFFFF);
      write_reg(CSR_RMS_OFFSET, 16'd0);
      write_reg(CSR_POWER_GAIN, 16'hFFFF);
      send_sample(10'd0, 1'b1);
      send_sample(10'd1023, 1'b1);
      wait_results();
      write_reg(CSR_RMS_OFFSET, 16'hFFFF);
      send_sample(10'd1023, 1'b1);
      wait_results();
      write_reg(CSR_POWER_GAIN, 16'd0);
      send_sample(10'd500, 1'b1);
      wait_results();
      // writes to an unmapped index change nothing
      write_reg(CsrUnmapped, 16'h1234);
      write_reg(CSR_ADC_BIAS, 16'd0);
      write_reg(CSR_RMS_OFFSET, 16'd0);
      write_reg(CSR_POWER_GAIN, 16'd256);
      send_sample(10'd1, 1'b1);
      wait_results();
      // tiny negative product must floor toward minus infinity
      write_reg(CSR_RMS_OFFSET, 16'd1);
      write_reg(CSR_POWER_GAIN, 16'd1);
      send_sample(10'd0, 1'b1);
      wait_results();
   endtask

   task automatic test_random_windows();
      int base;
      int phase;
      int nwin;
      base  = samples_sent;
      phase = 0;
      while (samples_sent - base < RandomItems) begin
         idle_on  = (phase % 3) != 2;
         stall_on = (phase % 4) != 3;
         if ($urandom_range(0, 2) != 0) write_reg(CSR_ADC_BIAS, pick_reg_value());
         if ($urandom_range(0, 2) != 0) write_reg(CSR_RMS_OFFSET, pick_reg_value());
         if ($urandom_range(0, 2) != 0) write_reg(CSR_POWER_GAIN, pick_reg_value());
         nwin = $urandom_range(3, 8);
         for (int w = 0; w < nwin; w++) begin
            send_window(pick_window_len());
            // hold the sender once until the meter has drained
            if (phase == 1 && w == 1) wait_results();
         end
         wait_results();
         phase++;
      end
   endtask

   initial begin : stall_gen
      int   hold;
      logic next;
      rsp_stall = 1'b0;
      hold      = 0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
         end else begin
            next = stall_on && ($urandom_range(0, 3) == 0);
            rsp_stall <= next;
            hold = next ? pick_gap() : $urandom_range(0, 12);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_result.rms      = rsp_rms_q8;
         got_result.power    = rsp_power_q8;
         got_result.count    = rsp_window_count;
         got_result.overflow = rsp_window_overflow;
         if (window_results_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("result with no window pending: rms %0d power %0d count %0d ovf %0b",
                        got_result.rms, $signed(got_result.power), got_result.count,
                        got_result.overflow);
         end else begin
            want_result = window_results_q.pop_front();
            windows_checked++;
            if (got_result.rms !== want_result.rms || got_result.power !== want_result.power ||
                got_result.count !== want_result.count ||
                got_result.overflow !== want_result.overflow) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("window %0d: expected rms %0d power %0d count %0d ovf %0b",
                           windows_checked, want_result.rms, $signed(want_result.power),
                           want_result.count, want_result.overflow);
                  $display("window %0d: got      rms %0d power %0d count %0d ovf %0b",
                           windows_checked, got_result.rms, $signed(got_result.power),
                           got_result.count, got_result.overflow);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timed out after %0d cycles with %0d windows pending", cycle_count,
                  window_results_q.size());
         $display("windowed_rms_power_meter: mismatch");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample      = '0;
      req_last_sample = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      bias_cfg        = 10'd511;
      offset_cfg      = 16'd242;
      gain_cfg        = 16'd2476;
      acc_sum         = '0;
      acc_count       = '0;
      acc_overflow    = 1'b0;
      error_count     = 0;
      windows_checked = 0;
      samples_sent    = 0;
      cycle_count     = 0;
      idle_on         = 1'b1;
      stall_on        = 1'b1;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_random_windows();

      $display("%0d samples in %0d windows checked, %0d errors", samples_sent,
               windows_checked, error_count);
      $display("covered register rails, unmapped writes, floor and clamp of power, random windows");
      if (error_count == 0) begin
         $display("windowed_rms_power_meter: match");
      end else begin
         $display("windowed_rms_power_meter: mismatch");
      end
      $finish;
   end

endmodule

// ===== windowed_rms_power_meter.f =====
hw/rtl/wrpm_pkg.sv
hw/rtl/wrpm_alu.sv
hw/rtl/wrpm_accum.sv
hw/rtl/wrpm_engine.sv
hw/rtl/windowed_rms_power_meter.sv
sim/tb_windowed_rms_power_meter.sv
